### rtl/ccsc_pkg.sv
package ccsc_pkg;

  localparam int FIELD_W          = 16;
  localparam int BOUNDS_W         = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int NUM_BOUNDS_DEF   = 4;
  // bits of the quotient root produced by the restoring root divider
  localparam int ROOT_BITS        = 19;
  localparam int FRONT_STAGES     = 5;
  localparam int LATENCY          = FRONT_STAGES + ROOT_BITS + 1;
  localparam int SITE_W           = 2;
  localparam int CFG_INDEX_W      = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_DX       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_DY       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_DZ       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_LIMIT  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_BOUNDS = 3'd7;

  localparam logic [FIELD_W-1:0] AXIS_DZ_RESET      = 16'd1024;
  localparam logic [FIELD_W-1:0] RADIUS_LIMIT_RESET = 16'd1024;

endpackage

### rtl/ccsc_front.sv
module ccsc_front import ccsc_pkg::*; #(
  parameter int CW = COORD_BITS_DEF,
  parameter int NW = 4 * CW + 6,
  parameter int DW = 2 * CW + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [FIELD_W-1:0] point_x,
  input  logic [FIELD_W-1:0] point_y,
  input  logic [FIELD_W-1:0] point_z,
  input  logic [FIELD_W-1:0] origin_x,
  input  logic [FIELD_W-1:0] origin_y,
  input  logic [FIELD_W-1:0] origin_z,
  input  logic [FIELD_W-1:0] axis_dx,
  input  logic [FIELD_W-1:0] axis_dy,
  input  logic [FIELD_W-1:0] axis_dz,
  output logic               out_valid,
  output logic               out_neg,
  output logic [NW-1:0]      out_d2,
  output logic [NW-1:0]      out_num,
  output logic [DW-1:0]      out_den
);

  localparam int VW   = CW + 1;
  localparam int PW   = 2 * CW + 2;
  localparam int DOTW = 2 * CW + 3;
  localparam int V2W  = 2 * CW + 4;

  logic signed [CW-1:0] ax, ay, az;
  assign ax = $signed(CW'(axis_dx));
  assign ay = $signed(CW'(axis_dy));
  assign az = $signed(CW'(axis_dz));

  // stage 1: offset from origin
  logic                 v1;
  logic signed [VW-1:0] vx, vy, vz;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    vx <= VW'($signed(CW'(point_x))) - VW'($signed(CW'(origin_x)));
    vy <= VW'($signed(CW'(point_y))) - VW'($signed(CW'(origin_y)));
    vz <= VW'($signed(CW'(point_z))) - VW'($signed(CW'(origin_z)));
  end

  // stage 2: products
  logic                 v2s;
  logic signed [PW-1:0] pax, pay, paz, pvx, pvy, pvz, pdx, pdy, pdz;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2s <= 1'b0;
    end else begin
      v2s <= v1;
    end
    pax <= PW'(ax) * PW'(vx);
    pay <= PW'(ay) * PW'(vy);
    paz <= PW'(az) * PW'(vz);
    pvx <= PW'(vx) * PW'(vx);
    pvy <= PW'(vy) * PW'(vy);
    pvz <= PW'(vz) * PW'(vz);
    pdx <= PW'(ax) * PW'(ax);
    pdy <= PW'(ay) * PW'(ay);
    pdz <= PW'(az) * PW'(az);
  end

  // stage 3: sums, zero axis fix, magnitude of the dot product
  logic signed [DOTW-1:0] dot_sum;
  logic [V2W-1:0]         v2_sum;
  logic [DW-1:0]          len_sum;
  always_comb begin
    dot_sum = DOTW'(pax) + DOTW'(pay) + DOTW'(paz);
    v2_sum  = V2W'($unsigned(pvx)) + V2W'($unsigned(pvy)) + V2W'($unsigned(pvz));
    len_sum = DW'($unsigned(pdx)) + DW'($unsigned(pdy)) + DW'($unsigned(pdz));
  end

  logic            v3;
  logic            neg3;
  logic [DOTW-1:0] dabs3;
  logic [V2W-1:0]  vv3;
  logic [DW-1:0]   len3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2s;
    end
    vv3 <= v2_sum;
    if (len_sum == '0) begin
      neg3  <= 1'b0;
      dabs3 <= '0;
      len3  <= DW'(1);
    end else begin
      neg3  <= dot_sum[DOTW-1];
      dabs3 <= dot_sum[DOTW-1] ? DOTW'(-dot_sum) : DOTW'(dot_sum);
      len3  <= len_sum;
    end
  end

  // stage 4: squares
  logic          v4, neg4;
  logic [NW-1:0] d2_4, vl4;
  logic [DW-1:0] len4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    neg4 <= neg3;
    len4 <= len3;
    d2_4 <= NW'(dabs3) * NW'(dabs3);
    vl4  <= NW'(vv3) * NW'(len3);
  end

  // stage 5: radial numerator, never negative
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    out_neg <= neg4;
    out_den <= len4;
    out_d2  <= d2_4;
    out_num <= vl4 - d2_4;
  end

endmodule

### rtl/ccsc_root_stage.sv
module ccsc_root_stage import ccsc_pkg::*; #(
  parameter int NW  = 70,
  parameter int DW  = 33,
  parameter int SW  = 73,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_neg,
  input  logic [NW-1:0]        in_hnum,
  input  logic [NW-1:0]        in_rnum,
  input  logic [DW-1:0]        in_den,
  input  logic [ROOT_BITS-1:0] in_hq,
  input  logic [SW-1:0]        in_hs,
  input  logic [SW-1:0]        in_hm,
  input  logic [ROOT_BITS-1:0] in_rq,
  input  logic [SW-1:0]        in_rs,
  input  logic [SW-1:0]        in_rm,
  output logic                 out_valid,
  output logic                 out_neg,
  output logic [NW-1:0]        out_hnum,
  output logic [NW-1:0]        out_rnum,
  output logic [DW-1:0]        out_den,
  output logic [ROOT_BITS-1:0] out_hq,
  output logic [SW-1:0]        out_hs,
  output logic [SW-1:0]        out_hm,
  output logic [ROOT_BITS-1:0] out_rq,
  output logic [SW-1:0]        out_rs,
  output logic [SW-1:0]        out_rm
);

  // try q + 2^BIT: (q+2^b)^2*den = s + 2^(b+1)*q*den + 2^(2b)*den
  logic [SW-1:0] den_sq, den_lin, ht, rt;
  logic          hok, rok;
  always_comb begin
    den_sq  = SW'(in_den) << (2 * BIT);
    den_lin = SW'(in_den) << BIT;
    ht      = in_hs + (in_hm << (BIT + 1)) + den_sq;
    rt      = in_rs + (in_rm << (BIT + 1)) + den_sq;
    hok     = ht <= SW'(in_hnum);
    rok     = rt <= SW'(in_rnum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_neg  <= in_neg;
    out_hnum <= in_hnum;
    out_rnum <= in_rnum;
    out_den  <= in_den;
    out_hq   <= hok ? (in_hq | (ROOT_BITS'(1) << BIT)) : in_hq;
    out_hs   <= hok ? ht : in_hs;
    out_hm   <= hok ? (in_hm + den_lin) : in_hm;
    out_rq   <= rok ? (in_rq | (ROOT_BITS'(1) << BIT)) : in_rq;
    out_rs   <= rok ? rt : in_rs;
    out_rm   <= rok ? (in_rm + den_lin) : in_rm;
  end

endmodule

### rtl/ccsc_classify.sv
module ccsc_classify import ccsc_pkg::*; #(
  parameter int NUM_BOUNDS = NUM_BOUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_neg,
  input  logic [ROOT_BITS-1:0] in_hq,
  input  logic [ROOT_BITS-1:0] in_rq,
  input  logic [FIELD_W-1:0]   radius_limit,
  input  logic [BOUNDS_W-1:0]  height_bounds,
  output logic                 result_valid,
  output logic [FIELD_W-1:0]   axial_height,
  output logic [FIELD_W-1:0]   radial_dist,
  output logic [SITE_W-1:0]    site_index
);

  localparam int HW = ROOT_BITS + 1;
  localparam logic signed [HW-1:0] H_MAX = HW'(32767);
  localparam logic signed [HW-1:0] H_MIN = -HW'(32768);

  logic signed [HW-1:0] h;
  logic [SITE_W-1:0]    site;
  logic [FIELD_W-1:0]   h_sat, r_sat;

  always_comb begin
    h    = in_neg ? -$signed(HW'(in_hq)) : $signed(HW'(in_hq));
    site = '0;
    // scan from the last boundary so the first exceeded one wins
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (h > HW'($signed(height_bounds[16*i +: 16]))) begin
        site = SITE_W'(i);
      end
    end
    if (in_rq > ROOT_BITS'(radius_limit)) begin
      site = '0;
    end
    if (h > H_MAX) begin
      h_sat = FIELD_W'(H_MAX);
    end else if (h < H_MIN) begin
      h_sat = FIELD_W'(H_MIN);
    end else begin
      h_sat = h[FIELD_W-1:0];
    end
    r_sat = (in_rq > ROOT_BITS'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : in_rq[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= in_valid;
    end
    axial_height <= h_sat;
    radial_dist  <= r_sat;
    site_index   <= site;
  end

endmodule

### rtl/axis_cylinder_coord_site_classifier.sv
// Streaming cylinder-coordinate classifier. Accepts one point per clock
// (start while busy is low; busy is high only during reset) and returns its
// axial height, radial distance and site index on a one-cycle result_valid
// strobe after the front stages of offset, products, sums, squares and
// radial numerator, the bit-per-stage root divider (one quotient bit per
// stage for height and radius side by side), and the classification and
// saturation stage. Results cannot be held off; capture them in the cycle
// they appear. Configuration writes take effect at once and must only be
// made with no item in flight.
module axis_cylinder_coord_site_classifier import ccsc_pkg::*; #(
  parameter int NUM_BOUNDS = NUM_BOUNDS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [FIELD_W-1:0]     point_x,
  input  logic [FIELD_W-1:0]     point_y,
  input  logic [FIELD_W-1:0]     point_z,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BOUNDS_W-1:0]    cfg_data,
  output logic                   result_valid,
  output logic [FIELD_W-1:0]     axial_height,
  output logic [FIELD_W-1:0]     radial_dist,
  output logic [SITE_W-1:0]      site_index
);

  localparam int NW  = 4 * COORD_BITS + 6;
  localparam int DW  = 2 * COORD_BITS + 1;
  localparam int SWA = (NW > 2 * ROOT_BITS + DW) ? NW : 2 * ROOT_BITS + DW;
  localparam int SW  = SWA + 2;

  logic [FIELD_W-1:0]  origin_x, origin_y, origin_z;
  logic [FIELD_W-1:0]  axis_dx, axis_dy, axis_dz, radius_limit;
  logic [BOUNDS_W-1:0] height_bounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      axis_dx       <= '0;
      axis_dy       <= '0;
      axis_dz       <= AXIS_DZ_RESET;
      radius_limit  <= RADIUS_LIMIT_RESET;
      height_bounds <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:      origin_x      <= cfg_data[FIELD_W-1:0];
        REG_ORIGIN_Y:      origin_y      <= cfg_data[FIELD_W-1:0];
        REG_ORIGIN_Z:      origin_z      <= cfg_data[FIELD_W-1:0];
        REG_AXIS_DX:       axis_dx       <= cfg_data[FIELD_W-1:0];
        REG_AXIS_DY:       axis_dy       <= cfg_data[FIELD_W-1:0];
        REG_AXIS_DZ:       axis_dz       <= cfg_data[FIELD_W-1:0];
        REG_RADIUS_LIMIT:  radius_limit  <= cfg_data[FIELD_W-1:0];
        REG_HEIGHT_BOUNDS: height_bounds <= cfg_data;
        default:           height_bounds <= height_bounds;
      endcase
    end
  end

  assign busy = rst;

  logic                 vld  [ROOT_BITS+1];
  logic                 neg  [ROOT_BITS+1];
  logic [NW-1:0]        hnum [ROOT_BITS+1];
  logic [NW-1:0]        rnum [ROOT_BITS+1];
  logic [DW-1:0]        den  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] hq   [ROOT_BITS+1];
  logic [SW-1:0]        hs   [ROOT_BITS+1];
  logic [SW-1:0]        hm   [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] rq   [ROOT_BITS+1];
  logic [SW-1:0]        rs   [ROOT_BITS+1];
  logic [SW-1:0]        rm   [ROOT_BITS+1];

  ccsc_front #(.CW(COORD_BITS), .NW(NW), .DW(DW)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .axis_dx(axis_dx), .axis_dy(axis_dy), .axis_dz(axis_dz),
    .out_valid(vld[0]), .out_neg(neg[0]), .out_d2(hnum[0]),
    .out_num(rnum[0]), .out_den(den[0])
  );

  assign hq[0] = '0;
  assign hs[0] = '0;
  assign hm[0] = '0;
  assign rq[0] = '0;
  assign rs[0] = '0;
  assign rm[0] = '0;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
    ccsc_root_stage #(.NW(NW), .DW(DW), .SW(SW), .BIT(ROOT_BITS - 1 - g)) u_stage (
      .clk(clk), .rst(rst),
      .in_valid(vld[g]), .in_neg(neg[g]), .in_hnum(hnum[g]), .in_rnum(rnum[g]),
      .in_den(den[g]), .in_hq(hq[g]), .in_hs(hs[g]), .in_hm(hm[g]),
      .in_rq(rq[g]), .in_rs(rs[g]), .in_rm(rm[g]),
      .out_valid(vld[g+1]), .out_neg(neg[g+1]), .out_hnum(hnum[g+1]),
      .out_rnum(rnum[g+1]), .out_den(den[g+1]), .out_hq(hq[g+1]),
      .out_hs(hs[g+1]), .out_hm(hm[g+1]), .out_rq(rq[g+1]),
      .out_rs(rs[g+1]), .out_rm(rm[g+1])
    );
  end

  ccsc_classify #(.NUM_BOUNDS(NUM_BOUNDS)) u_classify (
    .clk(clk), .rst(rst),
    .in_valid(vld[ROOT_BITS]), .in_neg(neg[ROOT_BITS]),
    .in_hq(hq[ROOT_BITS]), .in_rq(rq[ROOT_BITS]),
    .radius_limit(radius_limit), .height_bounds(height_bounds),
    .result_valid(result_valid), .axial_height(axial_height),
    .radial_dist(radial_dist), .site_index(site_index)
  );

endmodule

### rtl/ccsc_checker.sv
module ccsc_checker import ccsc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);

  // every strobe traces back to an item taken a fixed latency earlier
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted item");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY (result_valid || $past(rst, 1)))
    else $error("accepted item produced no result");

  a_flush_on_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !result_valid)
    else $error("result right after reset");

  a_busy_only_reset: assert property (@(posedge clk)
    busy == rst)
    else $error("busy outside reset");

endmodule

bind axis_cylinder_coord_site_classifier ccsc_checker u_ccsc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid)
);
